/* design/calday_pkg.sv */
// ----------------------------------------------------------------------------
// calday_pkg
// Shared types, constants and the month length lookup for the calendar
// day offset unit.
// ----------------------------------------------------------------------------
package calday_pkg;

    localparam logic [13:0] YEAR_MIN = 14'd1;
    localparam logic [13:0] YEAR_MAX = 14'd9999;

    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;

    localparam logic [5:0]  MINUTE_MAX = 6'd59;
    localparam logic [4:0]  HOUR_MAX   = 5'd23;
    localparam logic [4:0]  DAY_LAST   = 5'd31;
    localparam logic [4:0]  DAY_FIRST  = 5'd1;

    // floor(y / 100) = (y * 5243) >> 19 for every 14-bit y
    localparam logic [12:0] CENT_RECIP = 13'd5243;
    localparam int          CENT_SHIFT = 19;
    localparam logic [7:0]  CENT_DIV   = 8'd100;
    localparam logic [6:0]  YREM_LAST  = 7'd99;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic div;
        logic rem;
        logic check;
        logic step;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic finished;
    } t_status;

    // Days in a month; zero for a month number outside 1..12
    function automatic logic [4:0] month_length(input logic [3:0] month,
                                                input logic       leap);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

/* design/calday_ctrl.sv */
// ----------------------------------------------------------------------------
// calday_ctrl
// Sequencer: load, split the year into century and remainder, check the
// date, then step month by month until the offset is used up, the date is invalid or the year overflows.
// ----------------------------------------------------------------------------
module calday_ctrl
    import calday_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output logic    o_result_valid,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_REM   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_STEP  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_REM;
            end
            S_REM: begin
                o_cmd.rem = 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_STEP;
            end
            S_STEP: begin
                if (i_status.finished) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = (r_state == S_DONE);

endmodule

/* design/calday_dp.sv */
// ----------------------------------------------------------------------------
// calday_dp
// Date registers, year split into century and year-in-century for the leap
// test, and the one-month-per-cycle stepping logic.
// ----------------------------------------------------------------------------
module calday_dp
    import calday_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    input  logic [5:0]                    i_in_minute,
    input  logic [4:0]                    i_in_hour,
    input  logic [4:0]                    i_in_day,
    input  logic [3:0]                    i_in_month,
    input  logic [13:0]                   i_in_year,
    input  logic signed [OFFSET_BITS-1:0] i_day_offset,
    output logic [5:0]                    o_out_minute,
    output logic [4:0]                    o_out_hour,
    output logic [4:0]                    o_out_day,
    output logic [3:0]                    o_out_month,
    output logic [13:0]                   o_out_year,
    output logic                          o_date_valid,
    output logic                          o_year_overflow
);

    localparam int SW = ((OFFSET_BITS > 5) ? OFFSET_BITS : 5) + 1;

    logic [5:0]             r_minute;
    logic [4:0]             r_hour;
    logic [4:0]             r_day;
    logic [3:0]             r_month;
    logic [13:0]            r_year;
    logic [7:0]             r_cent;
    logic [6:0]             r_yrem;
    logic [26:0]            r_prod;
    logic [OFFSET_BITS-1:0] r_rem;
    logic                   r_back;
    logic                   r_valid;
    logic                   r_ovf;

    logic [OFFSET_BITS-1:0] w_raw;
    logic                   w_leap;
    logic [4:0]             w_len;
    logic [4:0]             w_prev_len;
    logic [3:0]             w_prev_month;
    logic [SW-1:0]          w_rem_x;
    logic [SW-1:0]          w_day_x;
    logic [SW-1:0]          w_len_x;
    logic [SW-1:0]          w_sum;
    logic [SW-1:0]          w_adv;
    logic [SW-1:0]          w_fwd_rem;
    logic [SW-1:0]          w_bwd_rem;
    logic [7:0]             w_cent;
    logic [13:0]            w_cent_x100;
    logic [13:0]            w_yrem_full;
    logic                   w_ok;

    assign w_raw  = i_day_offset;
    assign w_leap = ((r_year[1:0] == 2'd0) && (r_yrem != 7'd0)) ||
                    ((r_yrem == 7'd0) && (r_cent[1:0] == 2'd0));
    assign w_len  = month_length(r_month, w_leap);

    assign w_prev_month = (r_month == MONTH_JAN) ? MONTH_DEC : (r_month - 4'd1);
    assign w_prev_len   = month_length(w_prev_month, w_leap);

    assign w_rem_x   = SW'(r_rem);
    assign w_day_x   = SW'(r_day);
    assign w_len_x   = SW'(w_len);
    assign w_sum     = w_rem_x + w_day_x;
    assign w_adv     = w_len_x - w_day_x + SW'(1);
    assign w_fwd_rem = w_rem_x - w_adv;
    assign w_bwd_rem = w_rem_x - w_day_x;

    // Century and year-in-century both land together, ahead of the check
    assign w_cent      = r_prod[CENT_SHIFT +: 8];
    assign w_cent_x100 = 14'(w_cent) * 14'(CENT_DIV);
    assign w_yrem_full = r_year - w_cent_x100;

    assign w_ok = (r_minute <= MINUTE_MAX) && (r_hour <= HOUR_MAX) &&
                  (r_month >= MONTH_JAN) && (r_month <= MONTH_DEC) &&
                  (r_year >= YEAR_MIN) && (r_year <= YEAR_MAX) &&
                  (r_day >= DAY_FIRST) && (r_day <= w_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.load) begin
            r_valid <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.check) begin
            r_valid <= w_ok;
        end else if (i_cmd.step) begin
            if (!r_back && (w_sum > w_len_x) && (r_month == MONTH_DEC) &&
                (r_year == YEAR_MAX)) begin
                r_ovf <= 1'b1;
            end
            if (r_back && (w_rem_x >= w_day_x) && (r_month == MONTH_JAN) &&
                (r_year == YEAR_MIN)) begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_minute <= i_in_minute;
            r_hour   <= i_in_hour;
            r_day    <= i_in_day;
            r_month  <= i_in_month;
            r_year   <= i_in_year;
            r_back   <= w_raw[OFFSET_BITS-1];
            r_rem    <= w_raw[OFFSET_BITS-1] ? (~w_raw + OFFSET_BITS'(1)) : w_raw;
        end else if (i_cmd.div) begin
            r_prod <= 27'(r_year) * 27'(CENT_RECIP);
        end else if (i_cmd.rem) begin
            r_cent <= w_cent;
            r_yrem <= w_yrem_full[6:0];
        end else if (i_cmd.step) begin
            if (!r_back) begin
                if (w_sum <= w_len_x) begin
                    r_day <= w_sum[4:0];
                    r_rem <= '0;
                end else begin
                    r_rem <= w_fwd_rem[OFFSET_BITS-1:0];
                    r_day <= DAY_FIRST;
                    if (r_month == MONTH_DEC) begin
                        if (r_year == YEAR_MAX) begin
                            r_day <= DAY_LAST;
                        end else begin
                            r_month <= MONTH_JAN;
                            r_year  <= r_year + 14'd1;
                            if (r_yrem == YREM_LAST) begin
                                r_yrem <= 7'd0;
                                r_cent <= r_cent + 8'd1;
                            end else begin
                                r_yrem <= r_yrem + 7'd1;
                            end
                        end
                    end else begin
                        r_month <= r_month + 4'd1;
                    end
                end
            end else begin
                if (w_rem_x < w_day_x) begin
                    r_day <= r_day - w_rem_x[4:0];
                    r_rem <= '0;
                end else begin
                    r_rem <= w_bwd_rem[OFFSET_BITS-1:0];
                    if (r_month == MONTH_JAN) begin
                        if (r_year == YEAR_MIN) begin
                            r_day <= DAY_FIRST;
                        end else begin
                            r_month <= MONTH_DEC;
                            r_day   <= DAY_LAST;
                            r_year  <= r_year - 14'd1;
                            if (r_yrem == 7'd0) begin
                                r_yrem <= YREM_LAST;
                                r_cent <= r_cent - 8'd1;
                            end else begin
                                r_yrem <= r_yrem - 7'd1;
                            end
                        end
                    end else begin
                        r_month <= w_prev_month;
                        r_day   <= w_prev_len;
                    end
                end
            end
        end
    end

    assign o_status.finished = !r_valid || (r_rem == '0) || r_ovf;

    assign o_out_minute    = r_minute;
    assign o_out_hour      = r_hour;
    assign o_out_day       = r_day;
    assign o_out_month     = r_month;
    assign o_out_year      = r_year;
    assign o_date_valid    = r_valid;
    assign o_year_overflow = r_ovf;

endmodule

/* design/calendar_day_offset_unit.sv */
// ----------------------------------------------------------------------------
// calendar_day_offset_unit
// Adds a signed day offset to a Gregorian date-time and reports validity
// and year overflow.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the date-time fields and i_day_offset, then raise start. An item
//   is taken at a rising edge with start high and busy low; busy stays high
//   until the result has been presented.
//   The result appears on the o_ ports for exactly one cycle, marked by
//   o_result_valid. The receiver cannot stall: capture it in that cycle.
//   Sequence: after the accept edge, states S_DIV, S_REM and S_CHECK split
//   the year and check the date; the stepper then takes one step per month
//   boundary crossed, one more for any days left inside the last month, and
//   one to see the offset used up; the result follows in S_DONE. An invalid
//   date or a zero offset takes no steps. A full 16-bit offset crosses about
//   1080 months. One item at a time: the next is taken at the earliest in
//   the cycle after the result.
//   Reset (synchronous, active low) returns the sequencer to idle; no item
//   in flight survives it and no result is shown for it.
//   Invalid dates come back unchanged with o_date_valid low; leaving the
//   year range 1..9999 pins the date and raises o_year_overflow.
// ----------------------------------------------------------------------------
module calendar_day_offset_unit
    import calday_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [5:0]                    i_in_minute,
    input  logic [4:0]                    i_in_hour,
    input  logic [4:0]                    i_in_day,
    input  logic [3:0]                    i_in_month,
    input  logic [13:0]                   i_in_year,
    input  logic signed [OFFSET_BITS-1:0] i_day_offset,
    output logic                          o_result_valid,
    output logic [5:0]                    o_out_minute,
    output logic [4:0]                    o_out_hour,
    output logic [4:0]                    o_out_day,
    output logic [3:0]                    o_out_month,
    output logic [13:0]                   o_out_year,
    output logic                          o_date_valid,
    output logic                          o_year_overflow
);

    // Command and status between sequencer and datapath
    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer: idle, year split, check, month stepping, present result
    calday_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_cmd          (w_cmd),
        .i_status       (w_status)
    );

    // Datapath: hold the item, advance the date a month at a time
    calday_dp #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_in_minute     (i_in_minute),
        .i_in_hour       (i_in_hour),
        .i_in_day        (i_in_day),
        .i_in_month      (i_in_month),
        .i_in_year       (i_in_year),
        .i_day_offset    (i_day_offset),
        .o_out_minute    (o_out_minute),
        .o_out_hour      (o_out_hour),
        .o_out_day       (o_out_day),
        .o_out_month     (o_out_month),
        .o_out_year      (o_out_year),
        .o_date_valid    (o_date_valid),
        .o_year_overflow (o_year_overflow)
    );

endmodule

/* test/calendar_day_offset_unit_tb.sv */
// ----------------------------------------------------------------------------
// calendar_day_offset_unit_tb
// Self-checking bench for the calendar day offset unit. A short table of
// directed items covers the rejected fields, leap day rules, month and year
// wrap and both ends of the year range. A random run of well-formed dates
// with some noise follows. Every result is compared with a typed-in answer
// or with a date stepper held in the bench.
// ----------------------------------------------------------------------------
module calendar_day_offset_unit_tb
    import calday_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  OFFSET_W    = 16;
    localparam int  RANDOM_N    = 76;
    localparam int  PHASE_N     = 4;
    localparam int  SETTLE_CYC  = 40;       // longest quiet spell after the last result
    localparam int  CYCLE_LIMIT = 1000000;  // far above what 100 items need
    localparam int  REPORT_MAX  = 50;

    // One date-time with its offset, as presented to the unit
    typedef struct packed {
        logic [5:0]                 minute;
        logic [4:0]                 hour;
        logic [4:0]                 day;
        logic [3:0]                 month;
        logic [13:0]                year;
        logic signed [OFFSET_W-1:0] offset;
    } date_item_t;

    // What the unit should return for one item
    typedef struct packed {
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        valid;
        logic        ovf;
    } date_result_t;

    // Directed row: the item and, where it is obvious, the typed-in answer
    typedef struct packed {
        date_item_t   item;
        logic         typed;
        date_result_t want;
    } date_row_t;

    localparam date_result_t NONE = '0;

    localparam int DIRECTED_N = 24;
    localparam date_row_t DIRECTED [DIRECTED_N] = '{
        // start of the calendar, zero offset
        '{'{6'd0, 5'd0, 5'd1, 4'd1, 14'd1, 16'sd0}, 1'b1,
          '{6'd0, 5'd0, 5'd1, 4'd1, 14'd1, 1'b1, 1'b0}},
        // every field at all ones: rejected on the minute
        '{'{6'd63, 5'd31, 5'd31, 4'd15, 14'd16383, -16'sd1}, 1'b1,
          '{6'd63, 5'd31, 5'd31, 4'd15, 14'd16383, 1'b0, 1'b0}},
        '{'{6'd60, 5'd0, 5'd1, 4'd1, 14'd2000, 16'sd5}, 1'b1,
          '{6'd60, 5'd0, 5'd1, 4'd1, 14'd2000, 1'b0, 1'b0}},
        '{'{6'd59, 5'd24, 5'd1, 4'd1, 14'd2000, 16'sd5}, 1'b1,
          '{6'd59, 5'd24, 5'd1, 4'd1, 14'd2000, 1'b0, 1'b0}},
        // month zero and past December: the length lookup gives zero
        '{'{6'd0, 5'd0, 5'd1, 4'd0, 14'd2000, 16'sd5}, 1'b1,
          '{6'd0, 5'd0, 5'd1, 4'd0, 14'd2000, 1'b0, 1'b0}},
        '{'{6'd0, 5'd0, 5'd31, 4'd13, 14'd2000, 16'sd5}, 1'b1,
          '{6'd0, 5'd0, 5'd31, 4'd13, 14'd2000, 1'b0, 1'b0}},
        // year outside 1..9999
        '{'{6'd0, 5'd0, 5'd1, 4'd1, 14'd0, 16'sd5}, 1'b1,
          '{6'd0, 5'd0, 5'd1, 4'd1, 14'd0, 1'b0, 1'b0}},
        '{'{6'd0, 5'd0, 5'd1, 4'd1, 14'd10000, 16'sd5}, 1'b1,
          '{6'd0, 5'd0, 5'd1, 4'd1, 14'd10000, 1'b0, 1'b0}},
        // day zero, day past the month, leap day in a century year
        '{'{6'd0, 5'd0, 5'd0, 4'd3, 14'd2000, 16'sd5}, 1'b1,
          '{6'd0, 5'd0, 5'd0, 4'd3, 14'd2000, 1'b0, 1'b0}},
        '{'{6'd0, 5'd0, 5'd31, 4'd4, 14'd2000, 16'sd5}, 1'b1,
          '{6'd0, 5'd0, 5'd31, 4'd4, 14'd2000, 1'b0, 1'b0}},
        '{'{6'd0, 5'd0, 5'd29, 4'd2, 14'd1900, 16'sd5}, 1'b1,
          '{6'd0, 5'd0, 5'd29, 4'd2, 14'd1900, 1'b0, 1'b0}},
        // leap day in a 400 year, untouched
        '{'{6'd0, 5'd0, 5'd29, 4'd2, 14'd2000, 16'sd0}, 1'b1,
          '{6'd0, 5'd0, 5'd29, 4'd2, 14'd2000, 1'b1, 1'b0}},
        // month and year wraps, both directions; the December row is rejected on its hour
        '{'{6'd0, 5'd0, 5'd29, 4'd2, 14'd2024, 16'sd1}, 1'b0, NONE},
        '{'{6'd0, 5'd0, 5'd28, 4'd2, 14'd2023, 16'sd1}, 1'b0, NONE},
        '{'{6'd12, 5'd30, 5'd31, 4'd12, 14'd1999, 16'sd1}, 1'b0, NONE},
        '{'{6'd12, 5'd23, 5'd1, 4'd1, 14'd2000, -16'sd1}, 1'b0, NONE},
        '{'{6'd0, 5'd0, 5'd1, 4'd3, 14'd2100, -16'sd1}, 1'b0, NONE},
        // large offsets near either end of the calendar; running off an end pins the date
        '{'{6'd0, 5'd0, 5'd31, 4'd12, 14'd9999, 16'sd1}, 1'b1,
          '{6'd0, 5'd0, 5'd31, 4'd12, 14'd9999, 1'b1, 1'b1}},
        '{'{6'd0, 5'd0, 5'd1, 4'd1, 14'd1, -16'sd1}, 1'b1,
          '{6'd0, 5'd0, 5'd1, 4'd1, 14'd1, 1'b1, 1'b1}},
        '{'{6'd0, 5'd0, 5'd1, 4'd1, 14'd1, 16'sd32767}, 1'b0, NONE},
        '{'{6'd0, 5'd0, 5'd1, 4'd1, 14'd1, -16'sd32768}, 1'b1,
          '{6'd0, 5'd0, 5'd1, 4'd1, 14'd1, 1'b1, 1'b1}},
        '{'{6'd59, 5'd23, 5'd31, 4'd12, 14'd9999, -16'sd32768}, 1'b0, NONE},
        '{'{6'd59, 5'd23, 5'd1, 4'd1, 14'd9950, 16'sd32767}, 1'b0, NONE},
        '{'{6'd42, 5'd21, 5'd15, 4'd6, 14'd9999, 16'sd32767}, 1'b1,
          '{6'd42, 5'd21, 5'd31, 4'd12, 14'd9999, 1'b1, 1'b1}}
    };

    // Percentage of cycles the sender stays quiet, one entry per random phase.
    // The receiver cannot hold results off, so its stall phases run at full rate.
    localparam int IDLE_PCT [PHASE_N] = '{0, 81, 0, 38};

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [5:0]                 i_in_minute;
    logic [4:0]                 i_in_hour;
    logic [4:0]                 i_in_day;
    logic [3:0]                 i_in_month;
    logic [13:0]                i_in_year;
    logic signed [OFFSET_W-1:0] i_day_offset;
    logic                       o_result_valid;
    logic [5:0]                 o_out_minute;
    logic [4:0]                 o_out_hour;
    logic [4:0]                 o_out_day;
    logic [3:0]                 o_out_month;
    logic [13:0]                o_out_year;
    logic                       o_date_valid;
    logic                       o_year_overflow;

    date_result_t pending_dates [$];
    int           mismatches = 0;
    int           cycle_count = 0;

    calendar_day_offset_unit #(
        .OFFSET_BITS(OFFSET_W)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_in_minute    (i_in_minute),
        .i_in_hour      (i_in_hour),
        .i_in_day       (i_in_day),
        .i_in_month     (i_in_month),
        .i_in_year      (i_in_year),
        .i_day_offset   (i_day_offset),
        .o_result_valid (o_result_valid),
        .o_out_minute   (o_out_minute),
        .o_out_hour     (o_out_hour),
        .o_out_day      (o_out_day),
        .o_out_month    (o_out_month),
        .o_out_year     (o_out_year),
        .o_date_valid   (o_date_valid),
        .o_year_overflow(o_year_overflow)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: give up well beyond the slowest correct run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%t: run stopped at the cycle limit", $realtime);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic bit is_leap(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_days(int m, int y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Step the date one month at a time until the offset is used up,
    // pinning at either end of the calendar.
    function automatic date_result_t shift_date(date_item_t it);
        date_result_t r;
        int d, m, y, rem, len;
        bit back, ok, ovf;
        d    = it.day;
        m    = it.month;
        y    = it.year;
        back = it.offset[OFFSET_W-1];
        rem  = back ? -int'(it.offset) : int'(it.offset);
        ovf  = 1'b0;
        ok   = (it.minute <= MINUTE_MAX) && (it.hour <= HOUR_MAX)
               && (m >= MONTH_JAN) && (m <= MONTH_DEC)
               && (y >= YEAR_MIN) && (y <= YEAR_MAX);
        // only look up the length once the month is known to be sane
        if (ok)
            ok = (d >= 1) && (d <= month_days(m, y));
        if (ok && !back) begin
            while (rem > 0) begin
                len = month_days(m, y);
                if (d + rem <= len) begin
                    d   = d + rem;
                    rem = 0;
                end else begin
                    rem = rem - (len - d + 1);
                    d   = 1;
                    if (m == MONTH_DEC) begin
                        if (y == YEAR_MAX) begin
                            d   = 31;
                            ovf = 1'b1;
                            rem = 0;
                        end else begin
                            m = MONTH_JAN;
                            y = y + 1;
                        end
                    end else begin
                        m = m + 1;
                    end
                end
            end
        end else if (ok) begin
            while (rem > 0) begin
                if (rem < d) begin
                    d   = d - rem;
                    rem = 0;
                end else begin
                    rem = rem - d;
                    if (m == MONTH_JAN) begin
                        if (y == YEAR_MIN) begin
                            d   = 1;
                            ovf = 1'b1;
                            rem = 0;
                        end else begin
                            m = MONTH_DEC;
                            y = y - 1;
                        end
                    end else begin
                        m = m - 1;
                    end
                    if (!ovf)
                        d = month_days(m, y);
                end
            end
        end
        r.minute = it.minute;
        r.hour   = it.hour;
        r.day    = d[4:0];
        r.month  = m[3:0];
        r.year   = y[13:0];
        r.valid  = ok;
        r.ovf    = ovf;
        return r;
    endfunction

    // Mostly well-formed dates with random content, some hard against the
    // ends of the calendar; the rest is noise across the full field widths.
    function automatic date_item_t random_date();
        date_item_t it;
        int len;
        if ($urandom_range(99) < 15) begin
            it.minute = 6'($urandom_range(63));
            it.hour   = 5'($urandom_range(31));
            it.day    = 5'($urandom_range(31));
            it.month  = 4'($urandom_range(15));
            it.year   = 14'($urandom_range(16383));
            it.offset = OFFSET_W'($urandom);
        end else begin
            it.minute = 6'($urandom_range(59));
            it.hour   = 5'($urandom_range(23));
            it.month  = 4'($urandom_range(12, 1));
            case ($urandom_range(9))
                0:       it.year = 14'($urandom_range(3, 1));
                1:       it.year = 14'($urandom_range(9999, 9997));
                default: it.year = 14'($urandom_range(9999, 1));
            endcase
            len       = month_days(it.month, it.year);
            it.day    = 5'($urandom_range(len, 1));
            // keep most offsets short so the run stays brisk
            if ($urandom_range(3) == 0)
                it.offset = OFFSET_W'($urandom);
            else if ($urandom_range(1) == 0)
                it.offset = OFFSET_W'($urandom_range(800));
            else
                it.offset = OFFSET_W'(-$urandom_range(800));
        end
        return it;
    endfunction

    // Present one item from a falling edge, holding start until it is taken.
    // Returns on the falling edge after acceptance.
    task automatic present_date(input date_item_t it, input date_result_t want,
                                input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        i_in_minute  = it.minute;
        i_in_hour    = it.hour;
        i_in_day     = it.day;
        i_in_month   = it.month;
        i_in_year    = it.year;
        i_day_offset = it.offset;
        start        = 1'b1;
        do
            @(posedge i_clk);
        while (busy);
        pending_dates.push_back(want);
        @(negedge i_clk);
    endtask

    // Check every result strobe against the oldest outstanding date
    always @(posedge i_clk) begin
        date_result_t got;
        date_result_t want;
        if (i_rst_n && o_result_valid) begin
            got = '{o_out_minute, o_out_hour, o_out_day, o_out_month, o_out_year,
                    o_date_valid, o_year_overflow};
            if (pending_dates.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < REPORT_MAX)
                    $display("%t: unexpected result %0d:%0d %0d/%0d/%0d v%0b o%0b",
                             $realtime, got.hour, got.minute, got.day, got.month,
                             got.year, got.valid, got.ovf);
            end else begin
                want = pending_dates.pop_front();
                if (got !== want) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < REPORT_MAX) begin
                        $write("%t: expected %0d:%0d %0d/%0d/%0d v%0b o%0b,",
                               $realtime, want.hour, want.minute, want.day,
                               want.month, want.year, want.valid, want.ovf);
                        $display(" got %0d:%0d %0d/%0d/%0d v%0b o%0b",
                                 got.hour, got.minute, got.day, got.month,
                                 got.year, got.valid, got.ovf);
                    end
                end
            end
        end
    end

    initial begin
        date_item_t it;
        // hold every input at a known value through reset
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_in_minute  = '0;
        i_in_hour    = '0;
        i_in_day     = '0;
        i_in_month   = '0;
        i_in_year    = '0;
        i_day_offset = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table, back to back
        for (int row = 0; row < DIRECTED_N; row++) begin
            present_date(DIRECTED[row].item,
                         DIRECTED[row].typed ? DIRECTED[row].want
                                             : shift_date(DIRECTED[row].item),
                         0);
        end

        // random items, split across the idling phases
        for (int n = 0; n < RANDOM_N; n++) begin
            it = random_date();
            present_date(it, shift_date(it), IDLE_PCT[n * PHASE_N / RANDOM_N]);
        end
        start = 1'b0;

        // drain, then allow a quiet spell for any stray strobe
        while (pending_dates.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (mismatches == 0 && pending_dates.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
